FILE: sv/rip_pkg.sv
// ----------------------------------------------------------------------------
// rip_pkg
// Shared types, character codes and the digit lookup of the radix parser.
// ----------------------------------------------------------------------------
`default_nettype none

package rip_pkg;

  localparam int DEFAULT_MAX_INDEX_BITS = 8;

  localparam logic [5:0] RADIX_RESET      = 6'd10;
  localparam logic [6:0] MAX_DIGITS_RESET = 7'd64;
  localparam logic [5:0] RADIX_HEX        = 6'd16;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_X_UP  = 8'h58;
  localparam logic [7:0] CH_X_LO  = 8'h78;
  localparam logic [7:0] CH_A_UP  = 8'h41;
  localparam logic [7:0] CH_Z_UP  = 8'h5A;
  localparam logic [7:0] CH_A_LO  = 8'h61;
  localparam logic [7:0] CH_Z_LO  = 8'h7A;
  localparam logic [7:0] CASE_GAP = 8'h20;

  // Register file: index is paddr[2]
  typedef enum logic {
    REG_RADIX      = 1'b0,
    REG_MAX_DIGITS = 1'b1
  } reg_index_t;

  typedef enum logic [2:0] {
    PH_DONE   = 3'b001,
    PH_PREFIX = 3'b010,
    PH_DIGITS = 3'b100
  } phase_t;

  typedef enum logic [1:0] {
    STOP_EOS     = 2'd0,
    STOP_INVALID = 2'd1,
    STOP_LIMIT   = 2'd2
  } stop_reason_t;

  typedef struct packed {
    logic [63:0] acc;
    logic        neg;
    phase_t      phase;
    logic [6:0]  digits_left;
    logic        zero_pending;
  } parse_state_t;

  typedef struct packed {
    logic [63:0]  value;
    logic [7:0]   stop_index;
    stop_reason_t stop_reason;
  } result_t;

  typedef struct packed {
    logic       valid;
    logic [5:0] val;
  } digit_t;

  // Fold to upper case, then map 0-9 and A-Z to 0..35.
  function automatic digit_t digit_value(input logic [7:0] c);
    logic [7:0] u;
    digit_t     d;
    u = c;
    if (c >= CH_A_LO && c <= CH_Z_LO) begin
      u = c - CASE_GAP;
    end
    d.valid = 1'b0;
    d.val   = 6'd0;
    if (u >= CH_ZERO && u <= CH_NINE) begin
      d.valid = 1'b1;
      d.val   = 6'(u - CH_ZERO);
    end else if (u >= CH_A_UP && u <= CH_Z_UP) begin
      d.valid = 1'b1;
      d.val   = 6'(u - CH_A_UP) + 6'd10;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

FILE: sv/rip_stream_if.sv
// ----------------------------------------------------------------------------
// rip_char_if / rip_result_if
// Valid/ready channels carrying characters in and parse results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface rip_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       first;

  modport source (output valid, ch, first, input ready);
  modport sink   (input valid, ch, first, output ready);
endinterface

interface rip_result_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic [7:0]  stop_index;
  logic [1:0]  stop_reason;

  modport source (output valid, value, stop_index, stop_reason, input ready);
  modport sink   (input valid, value, stop_index, stop_reason, output ready);
endinterface

`default_nettype wire

FILE: sv/rip_step.sv
// ----------------------------------------------------------------------------
// rip_step
// One character of parsing: next state, character index and stop result.
// ----------------------------------------------------------------------------
`default_nettype none

module rip_step
  import rip_pkg::*;
#(
  parameter int MAX_INDEX_BITS = DEFAULT_MAX_INDEX_BITS
) (
  input  wire parse_state_t              st,
  input  wire logic [MAX_INDEX_BITS-1:0] cidx,
  input  wire logic [7:0]                ch,
  input  wire logic                      first,
  input  wire logic [5:0]                radix,
  input  wire logic [6:0]                max_digits,
  output parse_state_t                   st_next,
  output logic [MAX_INDEX_BITS-1:0]      cidx_next,
  output logic                           res_valid,
  output result_t                        res
);

  localparam int IW = MAX_INDEX_BITS;
  localparam int SW = (IW > 8) ? IW : 8;

  function automatic logic [IW-1:0] bump(input logic [IW-1:0] x);
    return (x == {IW{1'b1}}) ? x : x + 1'b1;
  endfunction

  parse_state_t  e;
  logic [IW-1:0] ei;
  logic [6:0]    dl;
  logic          take;
  logic          zero_stop;
  stop_reason_t  reason;
  digit_t        dv;
  logic [IW-1:0] sidx;
  logic [SW-1:0] sidx_w;

  assign dv = digit_value(ch);

  always_comb begin
    e  = st;
    ei = cidx;
    if (first) begin
      e.acc          = '0;
      e.neg          = 1'b0;
      e.digits_left  = max_digits;
      e.zero_pending = 1'b0;
      e.phase        = PH_PREFIX;
      ei             = '0;
    end

    st_next   = e;
    cidx_next = ei;
    res_valid = 1'b0;
    reason    = STOP_EOS;
    zero_stop = 1'b0;
    take      = 1'b0;
    dl        = e.digits_left;

    if (first && ch == CH_MINUS) begin
      st_next.neg = 1'b1;
      cidx_next   = bump(ei);
    end else begin
      unique case (e.phase)
        PH_DONE: begin
        end
        PH_PREFIX: begin
          if (e.zero_pending) begin
            // Held '0' resolves: either a hex prefix or a digit at its own index
            st_next.zero_pending = 1'b0;
            st_next.phase        = PH_DIGITS;
            if (ch == CH_X_LO || ch == CH_X_UP) begin
              cidx_next = bump(ei);
            end else if (dl == 7'd0) begin
              res_valid = 1'b1;
              zero_stop = 1'b1;
              reason    = STOP_LIMIT;
            end else if (radix == 6'd0) begin
              res_valid = 1'b1;
              zero_stop = 1'b1;
              reason    = STOP_INVALID;
            end else begin
              // accumulator is still zero in the prefix phase
              dl   = dl - 7'd1;
              take = 1'b1;
            end
          end else if (radix == RADIX_HEX && ch == CH_ZERO) begin
            st_next.zero_pending = 1'b1;
            cidx_next            = bump(ei);
          end else begin
            st_next.phase = PH_DIGITS;
            take          = 1'b1;
          end
        end
        PH_DIGITS: begin
          take = 1'b1;
        end
        default: begin
        end
      endcase

      if (take) begin
        st_next.digits_left = dl;
        priority if (ch == CH_NUL) begin
          res_valid = 1'b1;
          reason    = STOP_EOS;
        end else if (dl == 7'd0) begin
          res_valid = 1'b1;
          reason    = STOP_LIMIT;
        end else if (!dv.valid || dv.val >= radix) begin
          res_valid = 1'b1;
          reason    = STOP_INVALID;
        end else begin
          st_next.acc         = e.acc * 64'(radix) + 64'(dv.val);
          st_next.digits_left = dl - 7'd1;
          cidx_next           = bump(ei);
        end
      end

      if (res_valid) begin
        st_next.phase        = PH_DONE;
        st_next.zero_pending = 1'b0;
      end
    end
  end

  assign sidx   = zero_stop ? ei - 1'b1 : ei;
  assign sidx_w = SW'(sidx);

  always_comb begin
    res.value       = e.neg ? 64'd0 - e.acc : e.acc;
    res.stop_index  = (sidx_w > SW'(255)) ? 8'hFF : sidx_w[7:0];
    res.stop_reason = reason;
  end

endmodule

`default_nettype wire

FILE: sv/radix_integer_parser_unit.sv
// ----------------------------------------------------------------------------
// radix_integer_parser_unit
// Streaming string-to-integer parser with configurable radix and digit limit.
// ----------------------------------------------------------------------------
// One character is taken per clock cycle, back to back, while the result port
// does not stall, with first marking the start of a string. A character passes
// an input register, then parse logic (a 64-bit by 6-bit multiply and add,
// which sets the cycle time) into the result register; it leaves the input
// register once the result register is free. Only the stopping character
// gives a result; all others give none. Write radix and max_digits over the
// APB port only while no character is in flight; a write between two
// characters of a string applies to the characters that follow it.
`default_nettype none

module radix_integer_parser_unit
  import rip_pkg::*;
#(
  parameter int MAX_INDEX_BITS = DEFAULT_MAX_INDEX_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  rip_char_if.sink         char_in,
  rip_result_if.source     result,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [5:0] radix;
  logic [6:0] max_digits;
  reg_index_t reg_sel;

  assign reg_sel = reg_index_t'(paddr[2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix      <= RADIX_RESET;
      max_digits <= MAX_DIGITS_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_RADIX:      radix      <= pwdata[5:0];
        REG_MAX_DIGITS: max_digits <= pwdata[6:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_RADIX:      prdata = {26'd0, radix};
      REG_MAX_DIGITS: prdata = {25'd0, max_digits};
      default:        prdata = '0;
    endcase
  end

  // Input register
  logic       in_valid;
  logic [7:0] in_ch;
  logic       in_first;
  logic       out_valid;
  logic       out_free;
  logic       proc;

  assign out_free      = !out_valid || result.ready;
  assign proc          = in_valid && out_free;
  assign char_in.ready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (char_in.valid && char_in.ready) begin
      in_valid <= 1'b1;
    end else if (proc) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (char_in.valid && char_in.ready) begin
      in_ch    <= char_in.ch;
      in_first <= char_in.first;
    end
  end

  // Parse state
  parse_state_t              st;
  parse_state_t              st_next;
  logic [MAX_INDEX_BITS-1:0] char_index;
  logic [MAX_INDEX_BITS-1:0] char_index_next;
  logic                      res_valid;
  result_t                   res;

  rip_step #(
    .MAX_INDEX_BITS (MAX_INDEX_BITS)
  ) u_step (
    .st         (st),
    .cidx       (char_index),
    .ch         (in_ch),
    .first      (in_first),
    .radix      (radix),
    .max_digits (max_digits),
    .st_next    (st_next),
    .cidx_next  (char_index_next),
    .res_valid  (res_valid),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st.acc          <= '0;
      st.neg          <= 1'b0;
      st.phase        <= PH_DONE;
      st.digits_left  <= '0;
      st.zero_pending <= 1'b0;
      char_index      <= '0;
    end else if (proc) begin
      st         <= st_next;
      char_index <= char_index_next;
    end
  end

  // Result register
  result_t out_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc && res_valid) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && res_valid) begin
      out_q <= res;
    end
  end

  assign result.valid       = out_valid;
  assign result.value       = out_q.value;
  assign result.stop_index  = out_q.stop_index;
  assign result.stop_reason = out_q.stop_reason;

`ifndef ASSERT_OFF
  a_zero_pending_in_prefix: assert property (@(posedge clk) disable iff (rst)
    st.zero_pending |-> st.phase == PH_PREFIX)
    else $error("held zero outside prefix phase");

  a_result_from_input: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid))
    else $error("result appeared without a character in the input register");

  a_stop_ends_parse: assert property (@(posedge clk) disable iff (rst)
    proc && res_valid |=> st.phase == PH_DONE)
    else $error("parse did not stop after giving a result");

  a_input_held: assert property (@(posedge clk) disable iff (rst)
    in_valid && !out_free |=> in_valid && $stable(in_ch) && $stable(in_first))
    else $error("stalled input register lost its character");

  a_no_result_when_done: assert property (@(posedge clk) disable iff (rst)
    proc && !in_first && st.phase == PH_DONE |-> !res_valid)
    else $error("result given after parsing had stopped");
`endif

endmodule

`default_nettype wire
